### rtl/core/efdc_pkg.sv
// Package for the escaped frame decoder: register map, config and result types.
// No dependencies; imported by every module of the block.
package efdc_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] AngleByte = 8'h3C;

  typedef enum logic [2:0] {
    REG_LEADING_EN  = 3'd0,
    REG_LEADING_BYTE = 3'd1,
    REG_TERM_BYTE   = 3'd2,
    REG_ESCAPE_EN   = 3'd3,
    REG_ESCAPE_BYTE = 3'd4,
    REG_CHECKSUM_EN = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic       leading_en;
    logic [7:0] leading_byte;
    logic [7:0] term_byte;
    logic       escape_en;
    logic [7:0] escape_byte;
    logic       checksum_en;
  } cfg_t;

  // One queue entry: an optional payload beat followed by an optional end beat.
  typedef struct packed {
    logic       pay_vld;
    logic [7:0] pay_byte;
    logic       end_vld;
    status_e    status;
  } res_t;

endpackage

### rtl/core/efdc_regs.sv
// APB-style configuration registers of the frame decoder.
// Depends on efdc_pkg.
module efdc_regs import efdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LEADING_EN:   cfg_d.leading_en   = pwdata[0];
        REG_LEADING_BYTE: cfg_d.leading_byte = pwdata[7:0];
        REG_TERM_BYTE:    cfg_d.term_byte    = pwdata[7:0];
        REG_ESCAPE_EN:    cfg_d.escape_en    = pwdata[0];
        REG_ESCAPE_BYTE:  cfg_d.escape_byte  = pwdata[7:0];
        REG_CHECKSUM_EN:  cfg_d.checksum_en  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LEADING_EN:   prdata[0]   = cfg_q.leading_en;
      REG_LEADING_BYTE: prdata[7:0] = cfg_q.leading_byte;
      REG_TERM_BYTE:    prdata[7:0] = cfg_q.term_byte;
      REG_ESCAPE_EN:    prdata[0]   = cfg_q.escape_en;
      REG_ESCAPE_BYTE:  prdata[7:0] = cfg_q.escape_byte;
      REG_CHECKSUM_EN:  prdata[0]   = cfg_q.checksum_en;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/efdc_parse.sv
// Per-byte frame parser: escape handling, running checksum, one-byte hold-back.
// Depends on efdc_pkg; feeds efdc_resq with one entry per productive beat.
module efdc_parse import efdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       push_o,
  output res_t       entry_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_IN   = 2'd1,
    PH_ESC  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       nonempty_q, nonempty_d;
  logic       angle_q, angle_d;
  res_t       entry;

  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    nonempty_d = nonempty_q;
    angle_d    = angle_q;
    entry      = '{pay_vld: 1'b0, pay_byte: 8'h00, end_vld: 1'b0, status: STATUS_OK};

    if (phase_q == PH_IDLE && cfg_i.leading_en) begin
      if (rx_byte_i == cfg_i.leading_byte) begin
        phase_d = PH_IN;
      end
    end else if (phase_q != PH_ESC && cfg_i.escape_en && rx_byte_i == cfg_i.escape_byte) begin
      phase_d = PH_ESC;
    end else if (phase_q != PH_ESC && rx_byte_i == cfg_i.term_byte) begin
      // close
      if (!nonempty_q) begin
        entry.end_vld = 1'b1;
        entry.status  = STATUS_EMPTY;
      end else if (angle_q || !cfg_i.checksum_en) begin
        entry.pay_vld  = held_vld_q;
        entry.pay_byte = held_q;
        entry.end_vld  = 1'b1;
        entry.status   = STATUS_OK;
      end else begin
        entry.end_vld = 1'b1;
        entry.status  = (sum_q == 8'h00) ? STATUS_OK : STATUS_BAD;
      end
      phase_d    = PH_IDLE;
      sum_d      = 8'h00;
      held_d     = 8'h00;
      held_vld_d = 1'b0;
      nonempty_d = 1'b0;
      angle_d    = 1'b0;
    end else begin
      // payload byte: release the held one, hold this one
      entry.pay_vld  = held_vld_q;
      entry.pay_byte = held_q;
      if (!nonempty_q) begin
        angle_d = (rx_byte_i == AngleByte);
      end
      nonempty_d = 1'b1;
      held_d     = rx_byte_i;
      held_vld_d = 1'b1;
      sum_d      = sum_q + rx_byte_i;
      phase_d    = PH_IN;
    end
  end

  assign entry_o = entry;
  assign push_o  = accept_i & (entry.pay_vld | entry.end_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sum_q      <= 8'h00;
      held_q     <= 8'h00;
      held_vld_q <= 1'b0;
      nonempty_q <= 1'b0;
      angle_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      nonempty_q <= nonempty_d;
      angle_q    <= angle_d;
    end
  end

endmodule

### rtl/core/efdc_resq.sv
// Two-entry result queue; an entry drains as one or two output beats.
// Depends on efdc_pkg.
module efdc_resq import efdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t entry_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t head_o
);

  res_t       mem_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q;
  logic       split;
  logic       drop;

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  // payload and end in one entry: first beat only clears the payload part
  assign split   = pop_i & head_o.pay_vld & head_o.end_vld;
  assign drop    = pop_i & ~split;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
    if (split) begin
      mem_q[rd_ptr_q].pay_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (drop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, drop};
    end
  end

endmodule

### rtl/core/escaped_frame_decoder_with_checksum_top.sv
// Top level of the escaped frame decoder with additive checksum.
// Depends on efdc_pkg, efdc_regs, efdc_parse and efdc_resq.
//
// One received byte is taken per cycle; its parse and checksum update finish in
// that cycle and the results land in a two-entry output queue. Payload leaves
// one byte late; a frame close can yield two beats (last payload byte, then the
// end beat). The input stalls only while the queue holds two entries.
// Configure only while idle.
module escaped_frame_decoder_with_checksum_top import efdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           payload_byte_o,
  output logic                 payload_valid_o,
  output logic                 frame_end_o,
  output logic [1:0]           frame_status_o
);

  cfg_t cfg;
  res_t entry;
  res_t head;
  logic push;
  logic full;
  logic empty;
  logic accept;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = full;
  assign out_valid_o = ~empty;

  efdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efdc_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg),
    .push_o    (push),
    .entry_o   (entry)
  );

  efdc_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (out_valid_o & ~out_stall_i),
    .head_o  (head)
  );

  assign payload_valid_o = head.pay_vld;
  assign payload_byte_o  = head.pay_vld ? head.pay_byte : 8'h00;
  assign frame_end_o     = ~head.pay_vld;
  assign frame_status_o  = head.pay_vld ? 2'b00 : head.status;

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result queue");

  a_end_xor_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_valid_o != frame_end_o))
    else $error("result beat is neither or both payload and end");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (frame_status_o != 2'd3))
    else $error("illegal frame status");

  a_split_end_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && payload_valid_o && head.end_vld)
      |=> (out_valid_o && frame_end_o))
    else $error("end beat lost after last payload beat");

endmodule
